/* hw/rtl/morse_character_keyer_unit_defines.svh */
// Assertion macros for the Morse character keyer checker.
// No dependencies; include by bare file name.
`ifndef MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MCK_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("keyer check failed");

// Next-cycle implication, disabled during reset.
`define MCK_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("keyer check failed");

`endif

/* hw/rtl/mck_pkg.sv */
// Shared constants, types and the symbol lookup for the Morse character keyer.
// No dependencies.
package mck_pkg;

    localparam int TEMPO_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int USED_BITS  = (TEMPO_BITS < CFG_W) ? TEMPO_BITS : CFG_W;
    localparam int CHAR_W     = 8;
    localparam int DUR_W      = 18;
    localparam int CNT_W      = 3;
    localparam int PAT_W      = 5;
    localparam int SYM_COUNT  = 36;
    localparam int IDX_W      = 6;

    localparam logic [CHAR_W-1:0] DIGIT_FIRST  = 8'd48;
    localparam logic [CHAR_W-1:0] DIGIT_LAST   = 8'd57;
    localparam logic [CHAR_W-1:0] LETTER_FIRST = 8'd65;
    localparam logic [CHAR_W-1:0] LETTER_LAST  = 8'd90;
    localparam logic [CHAR_W-1:0] LETTER_BASE  = 8'd55;

    typedef logic [DUR_W-1:0] dur_t;

    typedef struct packed {
        dur_t unit1;
        dur_t unit2;
        dur_t unit3;
    } mck_dur_t;

    typedef struct packed {
        logic             is_code;
        logic [CNT_W-1:0] len;
        logic [PAT_W-1:0] dash;
    } mck_sym_t;

    // Element count, digits 0..9 then letters A..Z.
    localparam logic [CNT_W-1:0] SYM_LEN [SYM_COUNT] = '{
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    // Bit i set: element i (first sent is bit 0) is a dash.
    localparam logic [PAT_W-1:0] SYM_DASH [SYM_COUNT] = '{
        5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15,
        5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
        5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3
    };

    function automatic mck_sym_t mck_lookup(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] idx;
        mck_sym_t          s;
        s = '0;
        idx = '0;
        if (c >= DIGIT_FIRST && c <= DIGIT_LAST)
        begin
            idx = c - DIGIT_FIRST;
            s.is_code = 1'b1;
        end
        else if (c >= LETTER_FIRST && c <= LETTER_LAST)
        begin
            idx = c - LETTER_BASE;
            s.is_code = 1'b1;
        end
        s.len  = SYM_LEN[idx[IDX_W-1:0]];
        s.dash = SYM_DASH[idx[IDX_W-1:0]];
        return s;
    endfunction

endpackage

/* hw/rtl/mck_if.sv */
// Valid/ready channel interfaces: character items in, lamp segment items out.
// Depends on mck_pkg.
interface mck_char_if;
    logic                       valid;
    logic                       ready;
    logic [mck_pkg::CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface mck_seg_if;
    logic                      valid;
    logic                      ready;
    logic                      lamp_on;
    logic [mck_pkg::DUR_W-1:0] duration;
    logic                      last_segment;

    modport source (output valid, output lamp_on, output duration, output last_segment,
                    input ready);
    modport sink   (input valid, input lamp_on, input duration, input last_segment,
                    output ready);
endinterface

/* hw/rtl/mck_tempo.sv */
// Tempo register: holds one, two and three units of the written tempo.
// Depends on mck_pkg.
module mck_tempo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [mck_pkg::CFG_W-1:0] cfg_wdata,
    output mck_pkg::mck_dur_t         dur
);
    import mck_pkg::*;

    dur_t     unit1;
    dur_t     unit2;
    mck_dur_t dur_reg;
    mck_dur_t dur_next;

    assign unit1 = DUR_W'(cfg_wdata[USED_BITS-1:0]);
    assign unit2 = {unit1[DUR_W-2:0], 1'b0};

    always_comb
    begin
        dur_next = dur_reg;
        if (cfg_we)
        begin
            dur_next.unit1 = unit1;
            dur_next.unit2 = unit2;
            dur_next.unit3 = unit1 + unit2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg <= '0;
        end
        else
        begin
            dur_reg <= dur_next;
        end
    end

    assign dur = dur_reg;
endmodule

/* hw/rtl/mck_seg_gen.sv */
// Segment sequencer: shifts the dash pattern out one element per step
// into a registered output stage. Depends on mck_pkg and mck_if.
module mck_seg_gen (
    input  logic              clk,
    input  logic              rst_n,
    input  mck_pkg::mck_dur_t dur,
    mck_char_if.sink          char_in,
    mck_seg_if.source         seg_out
);
    import mck_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MARK  = 3'd1;
    localparam logic [2:0] ST_SPACE = 3'd2;
    localparam logic [2:0] ST_BREAK = 3'd3;
    localparam logic [2:0] ST_CLOSE = 3'd4;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [PAT_W-1:0] pat_reg;
    logic [PAT_W-1:0] pat_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             lamp_reg;
    logic             lamp_next;
    dur_t             dur_reg;
    dur_t             dur_next;
    logic             last_reg;
    logic             last_next;

    mck_sym_t sym;
    logic     in_fire;
    logic     step;
    logic     seg_lamp;
    dur_t     seg_dur;
    logic     seg_last;

    assign sym     = mck_lookup(char_in.char_code);
    assign char_in.ready = (state_reg == ST_IDLE);
    assign in_fire = char_in.valid && char_in.ready;
    assign step    = (state_reg != ST_IDLE) && (!out_valid_reg || seg_out.ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pat_next   = pat_reg;
        seg_lamp   = 1'b0;
        seg_dur    = dur.unit1;
        seg_last   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (sym.is_code)
                    begin
                        state_next = ST_MARK;
                        cnt_next   = sym.len;
                        pat_next   = sym.dash;
                    end
                    else
                    begin
                        state_next = ST_BREAK;
                        cnt_next   = CNT_ONE;
                    end
                end
            end
            ST_MARK:
            begin
                seg_lamp = 1'b1;
                seg_dur  = pat_reg[0] ? dur.unit3 : dur.unit1;
                if (step)
                begin
                    state_next = ST_SPACE;
                end
            end
            ST_SPACE:
            begin
                if (step)
                begin
                    pat_next   = pat_reg >> 1;
                    cnt_next   = cnt_reg - CNT_ONE;
                    state_next = (cnt_reg == CNT_ONE) ? ST_CLOSE : ST_MARK;
                end
            end
            ST_BREAK:
            begin
                seg_dur = dur.unit2;
                if (step)
                begin
                    state_next = ST_SPACE;
                end
            end
            ST_CLOSE:
            begin
                seg_dur  = dur.unit3;
                seg_last = 1'b1;
                if (step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        lamp_next      = lamp_reg;
        dur_next       = dur_reg;
        last_next      = last_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            lamp_next      = seg_lamp;
            dur_next       = seg_dur;
            last_next      = seg_last;
        end
        else if (seg_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        pat_reg  <= pat_next;
        lamp_reg <= lamp_next;
        dur_reg  <= dur_next;
        last_reg <= last_next;
    end

    assign seg_out.valid        = out_valid_reg;
    assign seg_out.lamp_on      = lamp_reg;
    assign seg_out.duration     = dur_reg;
    assign seg_out.last_segment = last_reg;
endmodule

/* hw/rtl/morse_character_keyer_unit.sv */
// Top level of the Morse character keyer: tempo register and segment sequencer.
// Depends on mck_pkg, mck_if, mck_tempo and mck_seg_gen.
//
// Each accepted character item yields its lamp segments in time order, one
// segment per cycle while the output side takes them: 2n+1 segments for a
// code of n elements (3 to 11), and 3 for a word break. The sequencer works
// on one character at a time and takes the next one the cycle after its
// closing gap enters the output register. Durations come from one, two and
// three tempo units precomputed when tempo is written; write tempo only
// while no character is in flight.
module morse_character_keyer_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [mck_pkg::CFG_W-1:0] cfg_wdata,
    mck_char_if.sink                  char_in,
    mck_seg_if.source                 seg_out
);
    import mck_pkg::*;

    mck_dur_t dur;

    mck_tempo u_tempo (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .dur       (dur)
    );

    mck_seg_gen u_seg_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .dur     (dur),
        .char_in (char_in),
        .seg_out (seg_out)
    );
endmodule

/* hw/rtl/mck_checker.sv */
// Port-level checks for the Morse character keyer and their bind.
// Depends on mck_pkg and morse_character_keyer_unit_defines.svh.
`include "morse_character_keyer_unit_defines.svh"

module mck_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      out_lamp_on,
    input logic [mck_pkg::DUR_W-1:0] out_duration,
    input logic                      out_last
);
    import mck_pkg::*;

    logic in_fire;
    logic out_stall;

    assign in_fire   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    `MCK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
        out_valid && $stable(out_lamp_on) && $stable(out_duration) && $stable(out_last))
    `MCK_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready)
    `MCK_ASSERT_NOW(a_last_is_dark, clk, rst_n, out_valid && out_last, !out_lamp_on)
    `MCK_ASSERT_NOW(a_idle_holds_last, clk, rst_n, in_ready && out_valid, out_last)
endmodule

bind morse_character_keyer_unit mck_checker u_mck_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (char_in.valid),
    .in_ready     (char_in.ready),
    .out_valid    (seg_out.valid),
    .out_ready    (seg_out.ready),
    .out_lamp_on  (seg_out.lamp_on),
    .out_duration (seg_out.duration),
    .out_last     (seg_out.last_segment)
);
